### design/cpm_pkg.sv
package cpm_pkg;

  // field widths fixed by the interface
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned TsW     = 16;
  localparam int unsigned MaskW   = 4;
  localparam int unsigned CountW  = 16;
  localparam int unsigned PeriodW = 16;

  // limit register file
  localparam int unsigned LimitRegs = 4;
  localparam int unsigned LimitW    = 16;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  // command codes carried in the mode field
  typedef enum logic [ModeW-1:0] {
    MODE_EDGE  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } cpm_mode_e;

  typedef logic [LimitW-1:0] cpm_limit_t;

  // one input word
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ChanW-1:0] channel;
    logic [TsW-1:0]   timestamp;
    logic [MaskW-1:0] sel_mask;
  } cpm_item_t;

  // one result word
  typedef struct packed {
    logic [CountW-1:0]  edge_count;
    logic               captured;
    logic               enabled;
    logic [PeriodW-1:0] period_ticks;
  } cpm_result_t;

endpackage

### design/multichannel_capture_period_meter.sv
// channel  | handshake                      | payload
// input    | in_valid_i / in_ready_o        | mode_i, channel_i, timestamp_i, sel_mask_i
// result   | out_valid_o / out_ready_i      | edge_count_o, captured_o, enabled_o, period_ticks_o
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// one word per cycle unless the result stalls; words pass the input, then the result register
// the channel update is a single read-modify-write between input and result registers
// reset clears all channel state and the limit registers to zero
// a stalled result holds the pipe; the input register still fills behind it
module multichannel_capture_period_meter #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned STAMP_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cpm_pkg::ModeW-1:0]     mode_i,
  input  logic [cpm_pkg::ChanW-1:0]     channel_i,
  input  logic [cpm_pkg::TsW-1:0]       timestamp_i,
  input  logic [cpm_pkg::MaskW-1:0]     sel_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cpm_pkg::CountW-1:0]    edge_count_o,
  output logic                          captured_o,
  output logic                          enabled_o,
  output logic [cpm_pkg::PeriodW-1:0]   period_ticks_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpm_pkg::AddrW-1:0]     paddr,
  input  logic [cpm_pkg::DataW-1:0]     pwdata,
  output logic [cpm_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import cpm_pkg::*;

  cpm_limit_t [LimitRegs-1:0] limits;
  cpm_item_t                  item_q;
  cpm_result_t                res_d, res_q;
  logic                       in_valid_q;
  logic                       out_valid_q;
  logic                       advance;
  logic                       upd;

  cpm_apb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .limits_o (limits)
  );

  // pipe control
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign upd        = in_valid_q && advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.mode      <= mode_i;
      item_q.channel   <= channel_i;
      item_q.timestamp <= timestamp_i;
      item_q.sel_mask  <= sel_mask_i;
    end
  end

  cpm_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (upd),
    .item_i   (item_q),
    .limits_i (limits),
    .result_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign edge_count_o   = res_q.edge_count;
  assign captured_o     = res_q.captured;
  assign enabled_o      = res_q.enabled;
  assign period_ticks_o = res_q.period_ticks;

endmodule

### design/cpm_apb_regs.sv
module cpm_apb_regs (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [cpm_pkg::AddrW-1:0]                paddr,
  input  logic [cpm_pkg::DataW-1:0]                pwdata,
  output logic [cpm_pkg::DataW-1:0]                prdata,
  output logic                                     pready,
  output cpm_pkg::cpm_limit_t [cpm_pkg::LimitRegs-1:0] limits_o
);
  import cpm_pkg::*;

  logic [LimitW-1:0] limit_q [LimitRegs];
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // limit registers, written in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LimitRegs; i++) limit_q[i] <= '0;
    end else if (wr_en) begin
      limit_q[reg_idx] <= pwdata[LimitW-1:0];
    end
  end

  // read back
  assign prdata = DataW'(limit_q[reg_idx]);

  always_comb begin
    for (int i = 0; i < LimitRegs; i++) limits_o[i] = limit_q[i];
  end

endmodule

### design/cpm_core.sv
module cpm_core #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned STAMP_WIDTH  = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         upd_i,
  input  cpm_pkg::cpm_item_t                           item_i,
  input  cpm_pkg::cpm_limit_t [cpm_pkg::LimitRegs-1:0] limits_i,
  output cpm_pkg::cpm_result_t                         result_o
);
  import cpm_pkg::*;

  logic [CountW-1:0]      count_q  [NUM_CHANNELS];
  logic [CountW-1:0]      count_d  [NUM_CHANNELS];
  logic [STAMP_WIDTH-1:0] first_q  [NUM_CHANNELS];
  logic [STAMP_WIDTH-1:0] first_d  [NUM_CHANNELS];
  logic [STAMP_WIDTH-1:0] second_q [NUM_CHANNELS];
  logic [STAMP_WIDTH-1:0] second_d [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] cap_q, cap_d;
  logic [NUM_CHANNELS-1:0] en_q, en_d;

  logic [STAMP_WIDTH-1:0] ts;
  logic [LimitW-1:0]      limit;
  logic [CountW-1:0]      cnt_inc;
  logic [STAMP_WIDTH-1:0] diff;

  assign ts    = STAMP_WIDTH'(item_i.timestamp);
  assign limit = limits_i[item_i.channel];

  // next state of every channel
  always_comb begin
    cnt_inc = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      count_d[i]  = count_q[i];
      first_d[i]  = first_q[i];
      second_d[i] = second_q[i];
      cap_d[i]    = cap_q[i];
      en_d[i]     = en_q[i];
      unique case (item_i.mode)
        MODE_EDGE: begin
          if (item_i.channel == ChanW'(i) && en_q[i]) begin
            cnt_inc    = count_q[i] + CountW'(1);
            count_d[i] = cnt_inc;
            if (cnt_inc >= limit) begin
              second_d[i] = ts;
              en_d[i]     = 1'b0;
              cap_d[i]    = 1'b1;
            end else begin
              first_d[i] = ts;
            end
          end
        end
        MODE_START: begin
          en_d[i] = item_i.sel_mask[i];
          if (item_i.sel_mask[i]) begin
            count_d[i] = '0;
            cap_d[i]   = 1'b0;
            first_d[i] = '0;
          end
        end
        MODE_STOP: begin
          if (item_i.sel_mask[i]) en_d[i] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        count_q[i]  <= '0;
        first_q[i]  <= '0;
        second_q[i] <= '0;
      end
      cap_q <= '0;
      en_q  <= '0;
    end else if (upd_i) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        count_q[i]  <= count_d[i];
        first_q[i]  <= first_d[i];
        second_q[i] <= second_d[i];
      end
      cap_q <= cap_d;
      en_q  <= en_d;
    end
  end

  // report the addressed channel after its update, zeros if out of range
  always_comb begin
    result_o = '0;
    diff     = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (item_i.channel == ChanW'(i)) begin
        diff                  = second_d[i] - first_d[i];
        result_o.edge_count   = count_d[i];
        result_o.captured     = cap_d[i];
        result_o.enabled      = en_d[i];
        result_o.period_ticks = PeriodW'(diff);
      end
    end
  end

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpm_pkg::*;

  localparam int unsigned Chans      = 4;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned SegWords   = 105;

  // spare mode code: reports the channel and changes nothing
  localparam logic [ModeW-1:0] MODE_PEEK = 2'd3;

  // limit register indexes
  typedef enum logic [ChanW-1:0] {
    LIM_CH0 = 2'd0,
    LIM_CH1 = 2'd1,
    LIM_CH2 = 2'd2,
    LIM_CH3 = 2'd3
  } limit_reg_e;

  typedef enum logic {
    ROW_WORD  = 1'b0,
    ROW_LIMIT = 1'b1
  } row_kind_e;

  // on a limit row, channel is the register index and stamp the value
  typedef struct packed {
    row_kind_e         kind;
    logic [ModeW-1:0]  mode;
    logic [ChanW-1:0]  channel;
    logic [TsW-1:0]    stamp;
    logic [MaskW-1:0]  mask;
    logic              typed;
    cpm_result_t       res;
  } row_t;

  localparam cpm_result_t Blank = '0;

  localparam row_t StimRows [24] = '{
    // after reset: nothing enabled, every limit zero
    '{ROW_WORD,  MODE_EDGE,  2'd0,    16'h1234, 4'h0, 1'b1, Blank},
    '{ROW_WORD,  MODE_PEEK,  2'd3,    16'hFFFF, 4'hF, 1'b1, Blank},
    '{ROW_WORD,  MODE_START, 2'd0,    16'h0000, 4'hF, 1'b1, '{16'd0, 1'b0, 1'b1, 16'd0}},
    // limit of zero: first edge finishes the capture
    '{ROW_WORD,  MODE_EDGE,  2'd0,    16'hFFFF, 4'h0, 1'b1, '{16'd1, 1'b1, 1'b0, 16'hFFFF}},
    // edge on a finished channel is ignored
    '{ROW_WORD,  MODE_EDGE,  2'd0,    16'h0000, 4'hF, 1'b1, '{16'd1, 1'b1, 1'b0, 16'hFFFF}},
    '{ROW_WORD,  MODE_STOP,  2'd1,    16'h0000, 4'h2, 1'b1, Blank},
    '{ROW_WORD,  MODE_EDGE,  2'd1,    16'h0005, 4'h0, 1'b1, Blank},
    // start with empty mask disables everything
    '{ROW_WORD,  MODE_START, 2'd2,    16'h0000, 4'h0, 1'b1, Blank},
    '{ROW_LIMIT, MODE_EDGE,  LIM_CH0, 16'd3,    4'h0, 1'b0, Blank},
    '{ROW_LIMIT, MODE_EDGE,  LIM_CH1, 16'hFFFF, 4'h0, 1'b0, Blank},
    '{ROW_LIMIT, MODE_EDGE,  LIM_CH2, 16'd1,    4'h0, 1'b0, Blank},
    '{ROW_LIMIT, MODE_EDGE,  LIM_CH3, 16'd2,    4'h0, 1'b0, Blank},
    // start keeps the old second stamp
    '{ROW_WORD,  MODE_START, 2'd0,    16'h0000, 4'hF, 1'b0, Blank},
    '{ROW_WORD,  MODE_EDGE,  2'd0,    16'h0010, 4'h0, 1'b0, Blank},
    '{ROW_WORD,  MODE_EDGE,  2'd0,    16'h0020, 4'h0, 1'b0, Blank},
    // period wraps below zero
    '{ROW_WORD,  MODE_EDGE,  2'd0,    16'h0005, 4'h0, 1'b0, Blank},
    '{ROW_WORD,  MODE_EDGE,  2'd1,    16'hAAAA, 4'h5, 1'b0, Blank},
    '{ROW_WORD,  MODE_EDGE,  2'd2,    16'h5555, 4'hA, 1'b0, Blank},
    '{ROW_WORD,  MODE_EDGE,  2'd3,    16'h8000, 4'h0, 1'b0, Blank},
    '{ROW_WORD,  MODE_STOP,  2'd3,    16'h0000, 4'h8, 1'b0, Blank},
    '{ROW_WORD,  MODE_EDGE,  2'd3,    16'h7FFF, 4'h0, 1'b0, Blank},
    '{ROW_WORD,  MODE_PEEK,  2'd1,    16'hFFFF, 4'hF, 1'b0, Blank},
    '{ROW_WORD,  MODE_STOP,  2'd1,    16'h0000, 4'hF, 1'b0, Blank},
    '{ROW_WORD,  MODE_EDGE,  2'd1,    16'h0001, 4'h0, 1'b0, Blank}
  };

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [ModeW-1:0]  mode_i         = '0;
  logic [ChanW-1:0]  channel_i      = '0;
  logic [TsW-1:0]    timestamp_i    = '0;
  logic [MaskW-1:0]  sel_mask_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [CountW-1:0] edge_count_o;
  logic              captured_o;
  logic              enabled_o;
  logic [PeriodW-1:0] period_ticks_o;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [AddrW-1:0]  paddr          = '0;
  logic [DataW-1:0]  pwdata         = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  multichannel_capture_period_meter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .channel_i     (channel_i),
    .timestamp_i   (timestamp_i),
    .sel_mask_i    (sel_mask_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .edge_count_o  (edge_count_o),
    .captured_o    (captured_o),
    .enabled_o     (enabled_o),
    .period_ticks_o(period_ticks_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the channel state
  cpm_limit_t       limit_val [Chans];
  logic [CountW-1:0] edge_cnt [Chans];
  logic [TsW-1:0]   stamp_a   [Chans];
  logic [TsW-1:0]   stamp_b   [Chans];
  logic             done_flag [Chans];
  logic             armed     [Chans];

  cpm_result_t pending_readings [$];
  int unsigned bad_fields  = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_req    = 0;
  int unsigned hold_ack    = 0;
  int unsigned hold_left   = 0;
  int unsigned quiet       = 0;
  logic [TsW-1:0] free_run = '0;

  // one word through the channel state, returns the reading it produces
  function automatic cpm_result_t meter_update(cpm_item_t w);
    cpm_result_t res;
    int unsigned c;
    c = w.channel;
    case (w.mode)
      MODE_EDGE: begin
        if (armed[c]) begin
          edge_cnt[c] = edge_cnt[c] + 16'd1;
          if (edge_cnt[c] >= limit_val[c]) begin
            stamp_b[c]   = w.timestamp;
            armed[c]     = 1'b0;
            done_flag[c] = 1'b1;
          end else begin
            stamp_a[c] = w.timestamp;
          end
        end
      end
      MODE_START: begin
        for (int i = 0; i < Chans; i++) armed[i] = 1'b0;
        for (int i = 0; i < Chans; i++) begin
          if (w.sel_mask[i]) begin
            edge_cnt[i]  = '0;
            done_flag[i] = 1'b0;
            stamp_a[i]   = '0;
            armed[i]     = 1'b1;
          end
        end
      end
      MODE_STOP: begin
        for (int i = 0; i < Chans; i++) begin
          if (w.sel_mask[i]) armed[i] = 1'b0;
        end
      end
      default: ;
    endcase
    res.edge_count   = edge_cnt[c];
    res.captured     = done_flag[c];
    res.enabled      = armed[c];
    res.period_ticks = stamp_b[c] - stamp_a[c];
    return res;
  endfunction

  // hold the word until taken, then log its reading
  task automatic offer_word(input cpm_item_t w, input logic typed, input cpm_result_t fixed);
    cpm_result_t predicted;
    in_valid_i     <= 1'b1;
    mode_i         <= w.mode;
    channel_i      <= w.channel;
    timestamp_i    <= w.timestamp;
    sel_mask_i     <= w.sel_mask;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = meter_update(w);
    pending_readings.push_back(typed ? fixed : predicted);
  endtask

  // random sender gaps, drawn anew after each idle cycle
  task automatic sender_gap();
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // drain all readings, then let the pipe settle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [ChanW-1:0] idx, input cpm_limit_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_val[idx] = val;
    // leave the bus idle between transfers
    @(posedge clk_i);
  endtask

  function automatic cpm_limit_t pick_limit();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return cpm_limit_t'($urandom_range(1, 6));
  endfunction

  // mostly edges on live channels with a rising timer, some commands and noise
  task automatic next_word(output cpm_item_t w, output logic counted);
    int unsigned r;
    int live [$];
    r = $urandom_range(0, 99);
    foreach (armed[i]) if (armed[i]) live.push_back(i);
    w.timestamp = TsW'($urandom_range(0, 65535));
    w.channel   = ChanW'($urandom_range(0, Chans - 1));
    w.sel_mask  = MaskW'($urandom_range(0, 15));
    if (r < 7 || (r >= 24 && live.size() == 0)) begin
      w.mode = MODE_START;
      if (r >= 24) w.sel_mask = MaskW'($urandom_range(1, 15));
    end else if (r < 12) begin
      w.mode = MODE_STOP;
    end else if (r < 16) begin
      w.mode = MODE_PEEK;
    end else begin
      w.mode = MODE_EDGE;
      if (r >= 24) begin
        w.channel = ChanW'(live[$urandom_range(0, live.size() - 1)]);
        if ($urandom_range(0, 3) != 0) begin
          free_run    = free_run + TsW'($urandom_range(1, 3000));
          w.timestamp = free_run;
        end
      end
    end
    counted = !(w.mode == MODE_EDGE && !armed[w.channel]);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_fields++;
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // compare each reading word with the oldest prediction
  always @(posedge clk_i) begin : reading_check
    cpm_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        $error("reading word with nothing pending");
        bad_fields++;
      end else begin
        want = pending_readings.pop_front();
        check_field("edge_count", want.edge_count, edge_count_o);
        check_field("captured", 16'(want.captured), 16'(captured_o));
        check_field("enabled", 16'(want.enabled), 16'(enabled_o));
        check_field("period_ticks", want.period_ticks, period_ticks_o);
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QuietLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    cpm_item_t w;
    logic counted;
    int unsigned n;
    foreach (armed[i]) begin
      limit_val[i] = '0;
      edge_cnt[i]  = '0;
      stamp_a[i]   = '0;
      stamp_b[i]   = '0;
      done_flag[i] = 1'b0;
      armed[i]     = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, no idling
    foreach (StimRows[k]) begin
      if (StimRows[k].kind == ROW_LIMIT) begin
        settle();
        write_limit(StimRows[k].channel, StimRows[k].stamp);
      end else begin
        w.mode      = StimRows[k].mode;
        w.channel   = StimRows[k].channel;
        w.timestamp = StimRows[k].stamp;
        w.sel_mask  = StimRows[k].mask;
        offer_word(w, StimRows[k].typed, StimRows[k].res);
      end
    end

    // random segments: receiver idles most, then sender idles most, then neither
    for (int seg = 0; seg < 6; seg++) begin
      settle();
      tx_idle_pct = (seg < 2) ? 32 : (seg < 4) ? 70 : 0;
      rx_idle_pct = (seg < 2) ? 70 : (seg < 4) ? 32 : 0;
      for (int r = 0; r < Chans; r++) write_limit(ChanW'(r), pick_limit());
      if (seg == 4) hold_req++;
      n = 0;
      while (n < SegWords) begin
        next_word(w, counted);
        offer_word(w, 1'b0, Blank);
        if (counted) n++;
        sender_gap();
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (bad_fields == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
